FILE: src/wst_pkg.sv
// Wakeup source table: shared types, codes and the sequencer microprogram.
// Used by wst_seq, wst_datapath and the top level. No dependencies.
package wst_pkg;

    localparam int KIND_W   = 2;
    localparam int UNIT_W   = 8;
    localparam int PERIOD_W = 32;
    localparam int STAT_W   = 2;
    localparam int RCNT_W   = 4;
    localparam int PC_W     = 4;

    localparam logic [KIND_W-1:0] KIND_PIN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TIMER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOCK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic REQ_SET   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [UNIT_W-1:0]   unit;
        logic [PERIOD_W-1:0] period;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_ST_INV,
        A_READ_IDX,
        A_SCAN,
        A_ST_NF,
        A_ST_OK,
        A_READ_NXT,
        A_SHIFT,
        A_DEC,
        A_ST_FULL,
        A_UPDATE,
        A_APPEND,
        A_EMIT
    } act_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_CLEAR,
        C_BAD,
        C_END,
        C_MATCH,
        C_LAST,
        C_FULL,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        pc_t   t_true;
        pc_t   t_false;
    } uword_t;

    typedef struct packed {
        logic accept;
        logic is_clear;
        logic set_bad;
        logic idx_end;
        logic match;
        logic last;
        logic full;
        logic out_free;
    } flags_t;

    localparam pc_t P_WAIT = 4'd0;
    localparam pc_t P_REQ  = 4'd1;
    localparam pc_t P_CHK  = 4'd2;
    localparam pc_t P_SRD  = 4'd3;
    localparam pc_t P_SCMP = 4'd4;
    localparam pc_t P_MISS = 4'd5;
    localparam pc_t P_HIT  = 4'd6;
    localparam pc_t P_SHRD = 4'd7;
    localparam pc_t P_SHWR = 4'd8;
    localparam pc_t P_DEC  = 4'd9;
    localparam pc_t P_APP  = 4'd10;
    localparam pc_t P_UPD  = 4'd11;
    localparam pc_t P_ADD  = 4'd12;
    localparam pc_t P_DONE = 4'd13;

    function automatic uword_t rom_word(input pc_t pc);
        uword_t w;
        case (pc)
            P_WAIT:  w = '{A_ACCEPT,   C_ACCEPT,   P_REQ,  P_WAIT};
            P_REQ:   w = '{A_NONE,     C_CLEAR,    P_SRD,  P_CHK};
            P_CHK:   w = '{A_ST_INV,   C_BAD,      P_DONE, P_SRD};
            P_SRD:   w = '{A_READ_IDX, C_END,      P_MISS, P_SCMP};
            P_SCMP:  w = '{A_SCAN,     C_MATCH,    P_HIT,  P_SRD};
            P_MISS:  w = '{A_ST_NF,    C_CLEAR,    P_DONE, P_APP};
            P_HIT:   w = '{A_ST_OK,    C_CLEAR,    P_SHRD, P_UPD};
            P_SHRD:  w = '{A_READ_NXT, C_LAST,     P_DEC,  P_SHWR};
            P_SHWR:  w = '{A_SHIFT,    C_ALWAYS,   P_SHRD, P_SHRD};
            P_DEC:   w = '{A_DEC,      C_ALWAYS,   P_DONE, P_DONE};
            P_APP:   w = '{A_ST_FULL,  C_FULL,     P_DONE, P_ADD};
            P_UPD:   w = '{A_UPDATE,   C_ALWAYS,   P_DONE, P_DONE};
            P_ADD:   w = '{A_APPEND,   C_ALWAYS,   P_DONE, P_DONE};
            P_DONE:  w = '{A_EMIT,     C_OUT_FREE, P_WAIT, P_DONE};
            default: w = '{A_NONE,     C_ALWAYS,   P_WAIT, P_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: src/wst_ram.sv
// Wakeup source table: generic single-write, single-read RAM, registered read.
// No dependencies.
module wst_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 8
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/wst_seq.sv
// Wakeup source table: microprogram sequencer (step counter, ROM, jumps).
// Depends on wst_pkg.
module wst_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  wst_pkg::flags_t flags,
    output wst_pkg::act_t   act
);

    wst_pkg::pc_t   pc_reg;
    wst_pkg::pc_t   pc_next;
    wst_pkg::uword_t uw;
    logic           taken;

    assign uw  = wst_pkg::rom_word(pc_reg);
    assign act = uw.act;

    always_comb begin
        case (uw.cond)
            wst_pkg::C_ALWAYS:   taken = 1'b1;
            wst_pkg::C_ACCEPT:   taken = flags.accept;
            wst_pkg::C_CLEAR:    taken = flags.is_clear;
            wst_pkg::C_BAD:      taken = flags.set_bad;
            wst_pkg::C_END:      taken = flags.idx_end;
            wst_pkg::C_MATCH:    taken = flags.match;
            wst_pkg::C_LAST:     taken = flags.last;
            wst_pkg::C_FULL:     taken = flags.full;
            wst_pkg::C_OUT_FREE: taken = flags.out_free;
            default:             taken = 1'b1;
        endcase
        pc_next = taken ? uw.t_true : uw.t_false;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= wst_pkg::P_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    a_pc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= wst_pkg::P_DONE)
        else $error("step counter outside program");

    a_wait_until_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == wst_pkg::P_WAIT && !flags.accept) |=> pc_reg == wst_pkg::P_WAIT)
        else $error("left wait step without a word");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == wst_pkg::P_DONE && !flags.out_free) |=> pc_reg == wst_pkg::P_DONE)
        else $error("result dropped while output busy");

endmodule

FILE: src/wst_datapath.sv
// Wakeup source table: request registers, record RAM, scan index, count, status.
// Depends on wst_pkg and wst_ram.
module wst_datapath #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wst_pkg::act_t                act,
    input  logic                         accept,
    input  logic                         out_free,
    input  logic                         in_req_type,
    input  logic [wst_pkg::KIND_W-1:0]   in_source_kind,
    input  logic [wst_pkg::UNIT_W-1:0]   in_unit_number,
    input  logic [wst_pkg::PERIOD_W-1:0] in_period_ms,
    input  logic [7:0]                   max_pin_number,
    output wst_pkg::flags_t              flags,
    output logic [wst_pkg::STAT_W-1:0]   status,
    output logic [wst_pkg::RCNT_W-1:0]   record_count
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic                         req_type_reg;
    logic [wst_pkg::KIND_W-1:0]   kind_reg;
    logic [wst_pkg::UNIT_W-1:0]   unit_reg;
    logic [wst_pkg::PERIOD_W-1:0] period_reg;
    logic [CNT_W-1:0]             idx_reg;
    logic [CNT_W-1:0]             idx_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [wst_pkg::STAT_W-1:0]   status_reg;
    logic [wst_pkg::STAT_W-1:0]   status_next;

    logic [CNT_W-1:0]   idx_inc;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    wst_pkg::rec_t      ram_wdata;
    wst_pkg::rec_t      ram_rdata;
    logic [31:0]        count_ext;
    logic               match;

    assign idx_inc = idx_reg + CNT_W'(1);

    assign match = (ram_rdata.kind == kind_reg) && (kind_reg != wst_pkg::KIND_BAD) &&
                   (ram_rdata.unit == unit_reg);

    always_comb begin
        flags          = '0;
        flags.accept   = accept;
        flags.out_free = out_free;
        flags.is_clear = (req_type_reg == wst_pkg::REQ_CLEAR);
        flags.set_bad  = ((kind_reg == wst_pkg::KIND_PIN) && (unit_reg > max_pin_number)) ||
                         ((kind_reg == wst_pkg::KIND_TIMER) && (period_reg == '0)) ||
                         (kind_reg == wst_pkg::KIND_BAD);
        flags.idx_end  = (idx_reg >= count_reg);
        flags.match    = match;
        flags.last     = (idx_inc >= count_reg);
        flags.full     = (count_reg == CNT_W'(TABLE_DEPTH));
    end

    always_comb begin
        idx_next    = idx_reg;
        count_next  = count_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[IDX_W-1:0];
        ram_raddr   = idx_reg[IDX_W-1:0];
        ram_wdata   = '{kind: kind_reg, unit: unit_reg, period: period_reg};
        unique case (act)
            wst_pkg::A_ACCEPT:   idx_next = '0;
            wst_pkg::A_ST_INV:   status_next = wst_pkg::ST_INVALID;
            wst_pkg::A_SCAN:     idx_next = match ? idx_reg : idx_inc;
            wst_pkg::A_ST_NF:    status_next = wst_pkg::ST_NOT_FOUND;
            wst_pkg::A_ST_OK:    status_next = wst_pkg::ST_OK;
            wst_pkg::A_READ_NXT: ram_raddr = idx_inc[IDX_W-1:0];
            wst_pkg::A_SHIFT: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                idx_next  = idx_inc;
            end
            wst_pkg::A_DEC:      count_next = count_reg - CNT_W'(1);
            wst_pkg::A_ST_FULL:  status_next = wst_pkg::ST_FULL;
            wst_pkg::A_UPDATE:   ram_we = 1'b1;
            wst_pkg::A_APPEND: begin
                ram_we      = 1'b1;
                ram_waddr   = count_reg[IDX_W-1:0];
                count_next  = count_reg + CNT_W'(1);
                status_next = wst_pkg::ST_OK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        if (act == wst_pkg::A_ACCEPT && accept) begin
            req_type_reg <= in_req_type;
            kind_reg     <= in_source_kind;
            unit_reg     <= in_unit_number;
            period_reg   <= in_period_ms;
        end
    end

    wst_ram #(
        .WIDTH (wst_pkg::REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count_ext    = 32'(count_reg);
    assign record_count = count_ext[wst_pkg::RCNT_W-1:0];
    assign status       = status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("record count above table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("record count moved by more than one");

    a_no_append_full: assert property (@(posedge aclk) disable iff (!aresetn)
        act == wst_pkg::A_APPEND |-> !flags.full)
        else $error("append into full table");

endmodule

FILE: src/wakeup_source_table_top.sv
// Wakeup source table: top level with handshakes, config register, output word.
// Depends on wst_pkg, wst_seq, wst_datapath (and wst_ram below it).
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tuser: req_type; s_tdata: kind, unit, period
//  m_      | out | m_tvalid / m_tready  | m_tdata: status, record_count
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data: max_pin_number
//
// The scan and the compacting shift go through one RAM read port: the scan reads and
// then compares each entry, the shift reads the next entry and then writes it back
// one place lower.
// Reset empties the table at once; no clearing pass. A stalled m_ side holds the
// finished word in its register; the next request is taken meanwhile and waits
// in its last step. cfg_ready is always high.
module wakeup_source_table_top #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [1:0] source_kind, [9:2] unit_number, [41:10] period_ms
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] status, [5:2] record_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    wst_pkg::act_t                act;
    wst_pkg::flags_t              flags;
    logic                         accept;
    logic                         out_free;
    logic [wst_pkg::STAT_W-1:0]   status;
    logic [wst_pkg::RCNT_W-1:0]   record_count;
    logic [7:0]                   max_pin_reg;
    logic                         m_tvalid_reg;
    logic [7:0]                   m_tdata_reg;

    assign s_tready  = (act == wst_pkg::A_ACCEPT);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    wst_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .act     (act)
    );

    wst_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .act            (act),
        .accept         (accept),
        .out_free       (out_free),
        .in_req_type    (s_tuser),
        .in_source_kind (s_tdata[1:0]),
        .in_unit_number (s_tdata[9:2]),
        .in_period_ms   (s_tdata[41:10]),
        .max_pin_number (max_pin_reg),
        .flags          (flags),
        .status         (status),
        .record_count   (record_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pin_reg  <= 8'd4;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_pin_reg <= cfg_data;
            end
            if (act == wst_pkg::A_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (act == wst_pkg::A_EMIT && out_free) begin
            m_tdata_reg <= {2'b00, record_count, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second word taken while request in progress");

    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(m_tdata_reg))
        else $error("pending result overwritten");

    a_no_emit_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !$rose(m_tvalid_reg))
        else $error("result shown before request was processed");

endmodule
